// ----- hdl/rgb_wave_pkg.sv -----
`timescale 1ns / 1ps

package rgb_wave_pkg;

   // Field and port widths
   localparam int LedW     = 2;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 8;

   // Register indexes on the csr port
   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENABLE     = 3'd0,
      CSR_MODE       = 3'd1,
      CSR_HUE_STEP   = 3'd2,
      CSR_SATURATION = 3'd3,
      CSR_WAVE_WIDTH = 3'd4,
      CSR_VALUE      = 3'd5,
      CSR_SCALE      = 3'd6
   } csr_index_type;

   // Effect modes (code 3 behaves as static)
   localparam logic [1:0] MODE_STATIC  = 2'd0;
   localparam logic [1:0] MODE_RAINBOW = 2'd1;
   localparam logic [1:0] MODE_WAVE    = 2'd2;

   // Fixed-point constants: 255 is 1.0
   localparam logic [8:0]  HUE_WRAP  = 9'd254;
   localparam logic [8:0]  HUE_FULL  = 9'd255;
   localparam logic [7:0]  LEVEL_MAX = 8'd255;
   localparam logic [15:0] FULL_SQ   = 16'd65025;
   // ceil(2^32 / 255): exact floor(n / 255) for any n below 2^24
   localparam logic [24:0] RECIP_255 = 25'd16843010;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_HUE,
      OP_LHUE,
      OP_SECT,
      OP_MULX,
      OP_MULN,
      OP_DIV1,
      OP_DIV2,
      OP_STORE,
      OP_MULS,
      OP_DIVS,
      OP_EMIT
   } op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LHUE,
      ST_SECT,
      ST_MULX,
      ST_MULN,
      ST_DIV1,
      ST_DIV2,
      ST_STORE,
      ST_MULS,
      ST_DIVS,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      op_type          op;
      logic [LedW-1:0] led;
      logic [1:0]      sel;   // level term (P, Q, T) or color channel (R, G, B)
      logic            last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic enable;
      logic convert;
      logic out_free;
   } status_type;

   // floor(n / 255) by reciprocal multiply
   function automatic logic [16:0] div255(input logic [23:0] n);
      logic [48:0] p;
      p = {25'd0, n} * {24'd0, RECIP_255};
      return p[48:32];
   endfunction

   // Sector of u = 6 * hue, that is floor(u / 255), by parallel compares
   function automatic logic [2:0] hsv_sector(input logic [10:0] u);
      logic [2:0] s;
      s = 3'd0;
      for (int k = 1; k <= 6; k++) begin
         if (u >= 11'(255 * k)) begin
            s = s + 3'd1;
         end
      end
      return s;
   endfunction

   // 255 * sector
   function automatic logic [10:0] sector_base(input logic [2:0] s);
      logic [10:0] b;
      unique case (s)
         3'd0:    b = 11'd0;
         3'd1:    b = 11'd255;
         3'd2:    b = 11'd510;
         3'd3:    b = 11'd765;
         3'd4:    b = 11'd1020;
         3'd5:    b = 11'd1275;
         3'd6:    b = 11'd1530;
         default: b = 11'd1785;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/rgb_wave_ctrl.sv -----
`timescale 1ns / 1ps

module rgb_wave_ctrl #(
   parameter int LED_COUNT = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_tick,
   output logic                     req_stall,
   input  rgb_wave_pkg::status_type status,
   output rgb_wave_pkg::cmd_type    cmd
);
   import rgb_wave_pkg::*;

   localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);

   state_type       state_ff, state_in;
   logic [LedW-1:0] led_ff, led_in;
   logic [1:0]      sel_ff, sel_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         led_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         led_ff   <= led_in;
         sel_ff   <= sel_in;
      end
   end

   // Sequencing: per LED convert (15 steps), then per LED scale and emit (7 steps)
   always_comb begin
      state_in  = state_ff;
      led_in    = led_ff;
      sel_in    = sel_ff;
      req_stall = 1'b1;
      cmd.op    = OP_NONE;
      cmd.led   = led_ff;
      cmd.sel   = sel_ff;
      cmd.last  = (led_ff == LastLed);

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            led_in    = '0;
            sel_in    = '0;
            if (req_valid && req_tick && status.enable) begin
               cmd.op   = OP_HUE;
               state_in = status.convert ? ST_LHUE : ST_MULS;
            end
         end
         ST_LHUE: begin
            cmd.op   = OP_LHUE;
            state_in = ST_SECT;
         end
         ST_SECT: begin
            cmd.op   = OP_SECT;
            sel_in   = '0;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            cmd.op   = OP_MULX;
            state_in = ST_MULN;
         end
         ST_MULN: begin
            cmd.op   = OP_MULN;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.op   = OP_DIV1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.op = OP_DIV2;
            if (sel_ff == 2'd2) begin
               sel_in   = '0;
               state_in = ST_STORE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_MULX;
            end
         end
         ST_STORE: begin
            cmd.op = OP_STORE;
            if (led_ff == LastLed) begin
               led_in   = '0;
               state_in = ST_MULS;
            end else begin
               led_in   = led_ff + LedW'(1);
               state_in = ST_LHUE;
            end
         end
         ST_MULS: begin
            cmd.op   = OP_MULS;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.op = OP_DIVS;
            if (sel_ff == 2'd2) begin
               sel_in   = '0;
               state_in = ST_EMIT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_MULS;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (led_ff == LastLed) begin
                  led_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  led_in   = led_ff + LedW'(1);
                  state_in = ST_MULS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/rgb_wave_dp.sv -----
`timescale 1ns / 1ps

module rgb_wave_dp #(
   parameter int LED_COUNT = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rgb_wave_pkg::cmd_type                  cmd,
   output rgb_wave_pkg::status_type               status,
   input  logic                                   csr_write_en,
   input  logic [rgb_wave_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [rgb_wave_pkg::CsrDataW-1:0]      csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rgb_wave_pkg::LedW-1:0]          rsp_led_index,
   output logic [7:0]                             rsp_red_out,
   output logic [7:0]                             rsp_green_out,
   output logic [7:0]                             rsp_blue_out,
   output logic                                   rsp_last_led
);
   import rgb_wave_pkg::*;

   // Configuration registers
   logic       enable_ff;
   logic [1:0] mode_ff;
   logic [7:0] hue_step_ff;
   logic [7:0] saturation_ff;
   logic [6:0] wave_width_ff;
   logic [7:0] value_ff;
   logic [7:0] scale_ff;

   // Working registers
   logic [7:0]  hue_ff;
   logic [7:0]  lhue_ff;
   logic [2:0]  sector_ff;
   logic [7:0]  frac_ff;
   logic [23:0] prod_ff;
   logic [16:0] quot_ff;
   logic [7:0]  lvl_ff [3];
   logic [7:0]  chan_ff [3];
   logic [23:0] color_ff [LED_COUNT];

   // Output register
   logic            rsp_valid_ff;
   logic [LedW-1:0] rsp_led_ff;
   logic [7:0]      rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic            rsp_last_ff;

   logic [8:0]  hue_sum;
   logic [7:0]  hue_in;
   logic [8:0]  led_offset;
   logic [8:0]  lhue_sum;
   logic [7:0]  lhue_in;
   logic [10:0] hue_x6;
   logic [2:0]  sector_in;
   logic [7:0]  frac_in;
   logic [7:0]  term_k;
   logic [7:0]  color_byte;
   logic [15:0] mul_a;
   logic [7:0]  mul_b;
   logic [23:0] mul_p;
   logic [23:0] div_src;
   logic [16:0] div_q;
   logic [23:0] rgb_in;

   // Hue advance with wrap past 254
   always_comb begin
      hue_sum = {1'b0, hue_ff} + {1'b0, hue_step_ff};
      hue_in  = (hue_sum > HUE_WRAP) ? 8'd0 : hue_sum[7:0];
   end

   // Per-LED hue: wave offset of led * width, folded back by 255
   always_comb begin
      led_offset = 9'd0;
      if (mode_ff == MODE_WAVE) begin
         unique case (cmd.led)
            2'd1:    led_offset = {2'b00, wave_width_ff};
            2'd2:    led_offset = {1'b0, wave_width_ff, 1'b0};
            default: led_offset = 9'd0;
         endcase
      end
      lhue_sum = {1'b0, hue_ff} + led_offset;
      lhue_in  = (lhue_sum > HUE_WRAP) ? 8'(lhue_sum - HUE_FULL) : lhue_sum[7:0];
   end

   // Sector and fraction of 6 * hue
   always_comb begin
      hue_x6    = {1'b0, lhue_ff, 2'b00} + {2'b00, lhue_ff, 1'b0};
      sector_in = hsv_sector(hue_x6);
      frac_in   = 8'(hue_x6 - sector_base(sector_in));
   end

   // Shared multiplier
   always_comb begin
      unique case (cmd.sel)
         2'd0:    term_k = LEVEL_MAX;
         2'd1:    term_k = frac_ff;
         default: term_k = LEVEL_MAX - frac_ff;
      endcase
      unique case (cmd.sel)
         2'd0:    color_byte = color_ff[cmd.led][23:16];
         2'd1:    color_byte = color_ff[cmd.led][15:8];
         default: color_byte = color_ff[cmd.led][7:0];
      endcase
      priority case (cmd.op)
         OP_MULX: begin
            mul_a = {8'd0, term_k};
            mul_b = saturation_ff;
         end
         OP_MULN: begin
            mul_a = FULL_SQ - prod_ff[15:0];
            mul_b = value_ff;
         end
         default: begin
            mul_a = {8'd0, color_byte};
            mul_b = scale_ff;
         end
      endcase
      mul_p = 24'(mul_a) * 24'(mul_b);
   end

   // Shared divide-by-255
   always_comb begin
      div_src = (cmd.op == OP_DIV2) ? {7'd0, quot_ff} : prod_ff;
      div_q   = div255(div_src);
   end

   // Six-sector color select; V, P, Q, T
   always_comb begin
      unique case (sector_ff)
         3'd0:    rgb_in = {value_ff, lvl_ff[2], lvl_ff[0]};
         3'd1:    rgb_in = {lvl_ff[1], value_ff, lvl_ff[0]};
         3'd2:    rgb_in = {lvl_ff[0], value_ff, lvl_ff[2]};
         3'd3:    rgb_in = {lvl_ff[0], lvl_ff[1], value_ff};
         3'd4:    rgb_in = {lvl_ff[2], lvl_ff[0], value_ff};
         3'd5:    rgb_in = {value_ff, lvl_ff[0], lvl_ff[1]};
         default: rgb_in = {LEVEL_MAX, LEVEL_MAX, LEVEL_MAX};
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         mode_ff       <= MODE_STATIC;
         hue_step_ff   <= 8'd1;
         saturation_ff <= 8'd255;
         wave_width_ff <= 7'd50;
         value_ff      <= 8'd255;
         scale_ff      <= 8'd255;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff     <= csr_data[0];
            CSR_MODE:       mode_ff       <= csr_data[1:0];
            CSR_HUE_STEP:   hue_step_ff   <= csr_data;
            CSR_SATURATION: saturation_ff <= csr_data;
            CSR_WAVE_WIDTH: wave_width_ff <= csr_data[6:0];
            CSR_VALUE:      value_ff      <= csr_data;
            CSR_SCALE:      scale_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // State that reset defines: hue and stored colors
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= 8'd1;
         for (int i = 0; i < LED_COUNT; i++) begin
            color_ff[i] <= '0;
         end
      end else begin
         if (cmd.op == OP_HUE) begin
            hue_ff <= hue_in;
         end
         if (cmd.op == OP_STORE) begin
            color_ff[cmd.led] <= rgb_in;
         end
      end
   end

   // Intermediate results
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LHUE) begin
         lhue_ff <= lhue_in;
      end
      if (cmd.op == OP_SECT) begin
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
      end
      if (cmd.op == OP_MULX || cmd.op == OP_MULN || cmd.op == OP_MULS) begin
         prod_ff <= mul_p;
      end
      if (cmd.op == OP_DIV1) begin
         quot_ff <= div_q;
      end
      if (cmd.op == OP_DIV2) begin
         lvl_ff[cmd.sel] <= div_q[7:0];
      end
      if (cmd.op == OP_DIVS) begin
         chan_ff[cmd.sel] <= div_q[7:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_led_ff   <= cmd.led;
         rsp_red_ff   <= chan_ff[0];
         rsp_green_ff <= chan_ff[1];
         rsp_blue_ff  <= chan_ff[2];
         rsp_last_ff  <= cmd.last;
      end
   end

   assign status.enable   = enable_ff;
   assign status.convert  = (mode_ff == MODE_RAINBOW) || (mode_ff == MODE_WAVE);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_led_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_last_led  = rsp_last_ff;

endmodule

// ----- hdl/rgb_rainbow_wave_effect_top.sv -----
// Rainbow / wave color effect for a string of LED_COUNT RGB LEDs (1 to 3).
// Request channel (req_valid, req_stall, req_tick): one beat per timer tick.
// A tick beat with req_tick low, or taken while the effect is disabled,
// produces nothing. Otherwise the stored hue advances and LED_COUNT response
// beats follow on rsp_*, one per LED in index order, rsp_last_led on the last.
// Config (csr_write_en, csr_index, csr_data) is to be written by the user only
// while the block is idle; the block itself does not enforce this.
// Rainbow and wave modes convert hue to RGB before output; static mode skips
// the conversion and rescales the stored colors. Cost is set by one shared
// multiplier and one shared divide-by-255 unit, stepped by the sequencer: 15
// steps per LED of HSV conversion, 7 steps per LED of scaling and output.
// req_stall is high while a tick is in progress; a new tick is taken the cycle
// after the last beat is loaded, even if that beat still waits in rsp_*.
// A stall on rsp_stall holds the beat in the output register and pauses the
// sequencer before the next beat. Synchronous reset clears the output, sets
// the hue to 1, clears the stored colors and loads the register defaults.
`timescale 1ns / 1ps

module rgb_rainbow_wave_effect_top #(
   parameter int LED_COUNT = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rgb_wave_pkg::LedW-1:0]       rsp_led_index,
   output logic [7:0]                          rsp_red_out,
   output logic [7:0]                          rsp_green_out,
   output logic [7:0]                          rsp_blue_out,
   output logic                                rsp_last_led,
   input  logic                                csr_write_en,
   input  logic [rgb_wave_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [rgb_wave_pkg::CsrDataW-1:0]   csr_data
);
   import rgb_wave_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   rgb_wave_ctrl #(
      .LED_COUNT (LED_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, state and output register
   rgb_wave_dp #(
      .LED_COUNT (LED_COUNT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_index (rsp_led_index),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_last_led  (rsp_last_led)
   );

endmodule

// ----- hdl/rgb_wave_chk.sv -----
`timescale 1ns / 1ps

module rgb_wave_chk #(
   parameter int LED_COUNT = 3
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rgb_wave_pkg::LedW-1:0] rsp_led_index,
   input logic [7:0]                    rsp_red_out,
   input logic [7:0]                    rsp_green_out,
   input logic [7:0]                    rsp_blue_out,
   input logic                          rsp_last_led
);
   import rgb_wave_pkg::*;

   localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);

   // Reset empties the output and opens the request side
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output or request stall not cleared by reset");

   // A stalled beat stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_led_index)
         && $stable(rsp_red_out) && $stable(rsp_green_out)
         && $stable(rsp_blue_out) && $stable(rsp_last_led)))
      else $error("stalled response beat changed");

   // The last flag marks exactly the highest LED
   a_last_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_led == (rsp_led_index == LastLed)))
      else $error("last_led does not match led_index");

   // LED order: where a taken beat that is not last is directly followed by a
   // valid beat, that beat is for the following LED
   a_led_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_led) ##1 rsp_valid
         |-> (rsp_led_index == $past(rsp_led_index) + LedW'(1)))
      else $error("LED beats out of order");

endmodule

bind rgb_rainbow_wave_effect_top rgb_wave_chk #(
   .LED_COUNT (LED_COUNT)
) u_rgb_wave_chk (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_led_index (rsp_led_index),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_last_led  (rsp_last_led)
);

// ----- sim/rgb_rainbow_wave_checker.sv -----
`timescale 1ns / 1ps

// Watches the tick, config and LED channels, predicts the LED beats of every
// accepted tick and compares them in order against what the block sends.
module rgb_rainbow_wave_checker #(
   parameter int LedCount = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_tick,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rgb_wave_pkg::LedW-1:0]     rsp_led_index,
   input  logic [7:0]                        rsp_red_out,
   input  logic [7:0]                        rsp_green_out,
   input  logic [7:0]                        rsp_blue_out,
   input  logic                              rsp_last_led,
   input  logic                              csr_write_en,
   input  logic [rgb_wave_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rgb_wave_pkg::CsrDataW-1:0] csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                checked
);
   import rgb_wave_pkg::*;

   typedef struct packed {
      logic [LedW-1:0] led;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic            last;
   } led_beat_type;

   // local copy of the effect registers
   logic        enable_r;
   logic [1:0]  mode_r;
   logic [7:0]  step_r;
   logic [7:0]  sat_r;
   logic [6:0]  width_r;
   logic [7:0]  value_r;
   logic [7:0]  scale_r;

   // effect state
   logic [7:0]  hue_r;
   logic [23:0] color_r [LedCount];

   led_beat_type led_beat_q [$];
   int           errors = 0;
   int           reported = 0;
   int           beats_seen = 0;

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

   // floor(V * (65025 - frac*sat) / 65025)
   function automatic logic [7:0] level_term(input int unsigned frac_sat);
      int unsigned num;
      num = 32'(value_r) * (32'd65025 - frac_sat);
      return 8'(num / 32'd65025);
   endfunction

   // six-sector HSV to packed {r, g, b}
   function automatic logic [23:0] hue_to_rgb(input int unsigned hue);
      int unsigned u;
      int unsigned sector;
      int unsigned fr;
      int unsigned s;
      logic [7:0]  v;
      logic [7:0]  p;
      logic [7:0]  q;
      logic [7:0]  t;
      logic [23:0] c;
      u      = (hue & 32'hFF) * 6;
      sector = u / 255;
      fr     = u % 255;
      s      = 32'(sat_r);
      v      = value_r;
      p      = level_term(255 * s);
      q      = level_term(fr * s);
      t      = level_term((255 - fr) * s);
      case (sector)
         0:       c = {v, t, p};
         1:       c = {q, v, p};
         2:       c = {p, v, t};
         3:       c = {p, q, v};
         4:       c = {t, p, v};
         5:       c = {v, p, q};
         default: c = 24'hFFFFFF;  // hue 255 gives white
      endcase
      return c;
   endfunction

   function automatic logic [7:0] scaled(input logic [7:0] lvl);
      int unsigned prod;
      prod = 32'(lvl) * 32'(scale_r);
      return 8'(prod / 255);
   endfunction

   // advance the hue, refresh the stored colors in rainbow or wave mode, queue one beat per LED; nothing while disabled
   task automatic predict_tick();
      int unsigned  sum;
      int unsigned  hues [3];
      led_beat_type b;
      if (!enable_r) return;
      sum   = 32'(hue_r) + 32'(step_r);
      hue_r = (sum > 254) ? 8'd0 : 8'(sum);
      for (int n = 0; n < 3; n++) hues[n] = 32'(hue_r);
      if (mode_r == MODE_WAVE) begin
         hues[1] = 32'(hue_r) + 32'(width_r);
         hues[2] = 32'(hue_r) + 2 * 32'(width_r);
         if (hues[1] > 254) hues[1] -= 255;
         if (hues[2] > 254) hues[2] -= 255;
      end
      if (mode_r == MODE_RAINBOW || mode_r == MODE_WAVE) begin
         for (int n = 0; n < LedCount; n++) color_r[n] = hue_to_rgb(hues[n]);
      end
      for (int n = 0; n < LedCount; n++) begin
         b.led   = LedW'(n);
         b.red   = scaled(color_r[n][23:16]);
         b.green = scaled(color_r[n][15:8]);
         b.blue  = scaled(color_r[n][7:0]);
         b.last  = (n == LedCount - 1);
         led_beat_q.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      led_beat_type got;
      led_beat_type want;
      if (reset) begin
         enable_r = 1'b0;
         mode_r   = MODE_STATIC;
         step_r   = 8'd1;
         sat_r    = 8'd255;
         width_r  = 7'd50;
         value_r  = 8'd255;
         scale_r  = 8'd255;
         hue_r    = 8'd1;
         for (int n = 0; n < LedCount; n++) color_r[n] = '0;
         led_beat_q.delete();
      end else begin
         // register writes, masked to each register's width
         if (csr_write_en) begin
            case (csr_index)
               CSR_ENABLE:     enable_r = csr_data[0];
               CSR_MODE:       mode_r   = csr_data[1:0];
               CSR_HUE_STEP:   step_r   = csr_data;
               CSR_SATURATION: sat_r    = csr_data;
               CSR_WAVE_WIDTH: width_r  = csr_data[6:0];
               CSR_VALUE:      value_r  = csr_data;
               CSR_SCALE:      scale_r  = csr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall && req_tick) predict_tick();

         // compare each LED beat with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_led_index, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_last_led};
            beats_seen++;
            if (led_beat_q.size() == 0) begin
               errors++;
               if (reported < 10) begin
                  $display("Unexpected LED beat: led %0d rgb %02h %02h %02h last %0b",
                           got.led, got.red, got.green, got.blue, got.last);
               end
               reported++;
            end else begin
               want = led_beat_q.pop_front();
               if (got.led !== want.led || got.red !== want.red ||
                   got.green !== want.green || got.blue !== want.blue ||
                   got.last !== want.last) begin
                  errors++;
                  if (reported < 10) begin
                     $display("LED beat mismatch: expected led %0d rgb %02h %02h %02h last %0b",
                              want.led, want.red, want.green, want.blue, want.last);
                     $display("                   got      led %0d rgb %02h %02h %02h last %0b",
                              got.led, got.red, got.green, got.blue, got.last);
                  end
                  reported++;
               end
            end
         end
      end
      fail_count <= errors;
      pending    <= led_beat_q.size();
      checked    <= beats_seen;
   end

endmodule

// ----- sim/rgb_rainbow_wave_effect_top_test.sv -----
`timescale 1ns / 1ps

module rgb_rainbow_wave_effect_top_test;
   import rgb_wave_pkg::*;

   localparam int                 LedCount    = 3;
   localparam logic [CsrIdxW-1:0] CsrUnused   = 3'd7;
   localparam logic [1:0]         ModeSpare   = 2'd3;
   localparam int                 HoldCycles  = 400;
   localparam int                 DrainCycles = 100;
   localparam int                 RandomTicks = 450;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_tick;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [LedW-1:0]     rsp_led_index;
   logic [7:0]          rsp_red_out;
   logic [7:0]          rsp_green_out;
   logic [7:0]          rsp_blue_out;
   logic                rsp_last_led;
   logic                csr_write_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_data;

   int   fail_count;
   int   pending;
   int   checked;

   // traffic shaping, shared with the receiver process
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_left = 0;

   logic cur_enable = 1'b0;
   int   tick_beats = 0;
   int   quiet_beats = 0;
   int   csr_writes = 0;

   rgb_rainbow_wave_effect_top #(
      .LED_COUNT(LedCount)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_tick     (req_tick),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_led_index(rsp_led_index),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .rsp_last_led (rsp_last_led),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   rgb_rainbow_wave_checker #(
      .LedCount(LedCount)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_tick     (req_tick),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_led_index(rsp_led_index),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .rsp_last_led (rsp_last_led),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hang guard
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // one register write; the block is idle whenever this is called
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [7:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ENABLE) cur_enable = data[0];
      csr_writes++;
   endtask

   // drop valid, wait out every expected beat, then let the sequencer go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // one tick beat, with optional idle cycles ahead of it
   task automatic send_tick(input logic tick_bit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_beats++;
      if (!tick_bit || !cur_enable) quiet_beats++;
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // random settings; raw data exercises the register width masking
   task automatic random_config();
      logic [1:0] mode_code;
      logic [7:0] width_data;
      case ($urandom_range(0, 5))
         0:       mode_code = MODE_STATIC;
         1, 2:    mode_code = MODE_RAINBOW;
         3, 4:    mode_code = MODE_WAVE;
         default: mode_code = ModeSpare;
      endcase
      case ($urandom_range(0, 4))
         0:       width_data = 8'h00;
         1:       width_data = 8'h7F;
         2:       width_data = 8'hFF;
         default: width_data = 8'($urandom);
      endcase
      write_reg(CSR_ENABLE, {7'($urandom), 1'($urandom_range(0, 7) != 0)});
      write_reg(CSR_MODE, {6'($urandom), mode_code});
      write_reg(CSR_HUE_STEP, pick_level());
      write_reg(CSR_SATURATION, pick_level());
      write_reg(CSR_WAVE_WIDTH, width_data);
      write_reg(CSR_VALUE, pick_level());
      write_reg(CSR_SCALE, pick_level());
      if ($urandom_range(0, 3) == 0) write_reg(CsrUnused, 8'($urandom));
   endtask

   // stimulus and verdict
   initial begin
      int   chunk;
      int   n;
      logic bit_v;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_tick     = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_ENABLE;
      csr_data     = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: nothing comes out
      send_tick(1'b1);
      send_tick(1'b0);

      // static mode re-emits the cleared colors; a zero tick does nothing
      settle();
      write_reg(CSR_ENABLE, 8'h01);
      send_tick(1'b1);
      send_tick(1'b0);

      // rainbow up to the top hue, then the wrap to zero and a zero step
      settle();
      write_reg(CSR_MODE, {6'd0, MODE_RAINBOW});
      write_reg(CSR_HUE_STEP, 8'd252);
      send_tick(1'b1);
      settle();
      write_reg(CSR_HUE_STEP, 8'd1);
      send_tick(1'b1);
      settle();
      write_reg(CSR_HUE_STEP, 8'd0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_HUE_STEP, 8'd255);
      send_tick(1'b1);

      // walk through all six sectors
      settle();
      write_reg(CSR_HUE_STEP, 8'd43);
      repeat (6) send_tick(1'b1);

      // gray, black, dark and half output
      settle();
      write_reg(CSR_SATURATION, 8'd0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_SATURATION, 8'd255);
      write_reg(CSR_VALUE, 8'd0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_VALUE, 8'd255);
      write_reg(CSR_SCALE, 8'd0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_SCALE, 8'd128);
      send_tick(1'b1);

      // wave with zero and widest offset (top data bit masked away)
      settle();
      write_reg(CSR_MODE, {6'd0, MODE_WAVE});
      write_reg(CSR_WAVE_WIDTH, 8'd0);
      send_tick(1'b1);
      settle();
      write_reg(CSR_WAVE_WIDTH, 8'hFF);
      send_tick(1'b1);
      send_tick(1'b1);

      // mode code 3 acts as static, then static proper
      settle();
      write_reg(CSR_MODE, 8'hFF);
      send_tick(1'b1);
      settle();
      write_reg(CSR_MODE, {6'd0, MODE_STATIC});
      send_tick(1'b1);

      // write to an unused index changes nothing
      settle();
      write_reg(CsrUnused, 8'h00);
      send_tick(1'b1);

      // enable cleared through a masked write
      settle();
      write_reg(CSR_ENABLE, 8'hFE);
      send_tick(1'b1);

      // back-pressure: receiver holds off while ticks keep coming
      settle();
      write_reg(CSR_ENABLE, 8'h01);
      write_reg(CSR_MODE, {6'd0, MODE_RAINBOW});
      write_reg(CSR_HUE_STEP, 8'd7);
      hold_left = HoldCycles;
      repeat (8) send_tick(1'b1);

      // random phases, cycling through the idle patterns
      chunk = 0;
      while (tick_beats < RandomTicks) begin
         case (chunk % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 79;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 79;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase
         settle();
         random_config();
         n = $urandom_range(20, 40);
         repeat (n) begin
            bit_v = ($urandom_range(0, 9) != 0);
            send_tick(bit_v);
         end
         chunk++;
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      settle();

      $display("Sent %0d tick beats (%0d with no LED output), checked %0d LED beats",
               tick_beats, quiet_beats, checked);
      $display("%0d register writes over directed, back-pressure and %0d random phases",
               csr_writes, chunk);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
